/* rtl/core/rpn_stack_evaluator_unit_assert.svh */
// Assertion macros for the stack evaluator.
// Used by rpn_stack_evaluator_unit; no other dependencies.
`ifndef RPN_STACK_EVALUATOR_UNIT_ASSERT_SVH
`define RPN_STACK_EVALUATOR_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define RSE_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define RSE_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define RSE_ASSERT(label, clk, rst, prop, msg)
`define RSE_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

/* rtl/core/rpn_pkg.sv */
// Shared types and constants for the stack evaluator.
// No dependencies.
package rpn_pkg;
  localparam int unsigned StackDepthDefault = 64;

  typedef struct packed {
    logic        cmd;
    logic [30:0] operand;
    logic [2:0]  op_code;
    logic        last;
  } token_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         error;
  } result_t;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0, ERR_UNDERFLOW = 2'd1, ERR_OVERFLOW = 2'd2, ERR_DIVZERO = 2'd3
  } err_t;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2, OP_DIV = 3'd3, OP_REM = 3'd4
  } op_t;

  localparam logic CMD_OPERAND = 1'b0;
  localparam logic CMD_OPERATOR = 1'b1;
endpackage

/* rtl/core/rpn_fifo.sv */
// Two-entry token queue between front and back.
// Depends on rpn_pkg.
module rpn_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rpn_pkg::token_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output rpn_pkg::token_t pop_data
);
  rpn_pkg::token_t mem [2];
  logic       wp, rp;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = mem[rp];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_data;
  end
endmodule

/* rtl/core/rpn_divider.sv */
// Iterative signed divider, one quotient bit per cycle.
// No package dependencies.
module rpn_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient,
  output logic [31:0] remainder
);
  logic [31:0] q, d;
  logic [32:0] r;
  logic [5:0]  cnt;
  logic        busy, neg_q, neg_r;
  logic [32:0] trial;
  logic [31:0] a_abs, b_abs;

  assign a_abs = dividend[31] ? 32'(-dividend) : dividend;
  assign b_abs = divisor[31] ? 32'(-divisor) : divisor;
  assign trial = {r[31:0], q[31]} - {1'b0, d};

  // restoring shift-subtract loop
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= 6'd32;
        q     <= a_abs;
        d     <= b_abs;
        r     <= '0;
        neg_q <= dividend[31] ^ divisor[31];
        neg_r <= dividend[31];
      end else if (busy) begin
        if (trial[32]) begin
          r <= {r[31:0], q[31]};
          q <= {q[30:0], 1'b0};
        end else begin
          r <= trial;
          q <= {q[30:0], 1'b1};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = neg_q ? 32'(-q) : q;
  assign remainder = neg_r ? 32'(-r[31:0]) : r[31:0];
endmodule

/* rtl/core/rpn_back.sv */
// Execution engine: value stack, ALU, divider sequencing, result register.
// Depends on rpn_pkg, rpn_divider.
module rpn_back #(
  parameter int unsigned STACK_DEPTH = rpn_pkg::StackDepthDefault
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            mode,
  input  logic            tok_valid,
  input  rpn_pkg::token_t tok,
  output logic            tok_pop,
  output logic            busy,
  output logic            res_valid,
  input  logic            res_stall,
  output rpn_pkg::result_t res
);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_RD1, S_RD2, S_EXEC, S_DIV, S_FIN, S_RDW, S_OUT
  } state_t;

  logic [31:0] stack_mem [STACK_DEPTH];
  state_t      state;
  logic [DW-1:0] depth;
  rpn_pkg::err_t err;
  rpn_pkg::token_t cur;
  logic [31:0] rd_data, first, second;
  logic [AW-1:0] rd_addr;
  logic        wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0] wr_data;
  logic        div_start, div_done;
  logic [31:0] quo, rem, lhs, rhs, alu;
  logic [31:0] prod;

  assign lhs = mode ? first : second;
  assign rhs = mode ? second : first;
  assign prod = lhs * rhs;

  // non-divide ALU
  always_comb begin
    case (rpn_pkg::op_t'(cur.op_code))
      rpn_pkg::OP_ADD: alu = lhs + rhs;
      rpn_pkg::OP_SUB: alu = lhs - rhs;
      default:         alu = prod;
    endcase
  end

  rpn_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(lhs), .divisor(rhs),
    .done(div_done), .quotient(quo), .remainder(rem)
  );

  // stack memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) stack_mem[wr_addr] <= wr_data;
    rd_data <= stack_mem[rd_addr];
  end

  assign tok_pop = (state == S_IDLE) && tok_valid;
  assign busy    = (state != S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      depth     <= '0;
      err       <= rpn_pkg::ERR_NONE;
      res_valid <= 1'b0;
      div_start <= 1'b0;
      wr_en     <= 1'b0;
    end else begin
      div_start <= 1'b0;
      wr_en     <= 1'b0;
      if (res_valid && !res_stall) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (tok_valid) begin
          cur <= tok;
          if (tok.cmd == rpn_pkg::CMD_OPERAND) begin
            if (DW'(STACK_DEPTH) <= depth) begin
              if (err == rpn_pkg::ERR_NONE) err <= rpn_pkg::ERR_OVERFLOW;
            end else begin
              wr_en   <= 1'b1;
              wr_addr <= AW'(depth);
              wr_data <= {1'b0, tok.operand};
              depth   <= depth + DW'(1);
            end
            state <= S_FIN;
          end else if (tok.op_code > 3'd4) begin
            state <= S_FIN;
          end else if (depth < DW'(2)) begin
            if (err == rpn_pkg::ERR_NONE) err <= rpn_pkg::ERR_UNDERFLOW;
            state <= S_FIN;
          end else begin
            rd_addr <= AW'(depth - DW'(1));
            state   <= S_RD1;
          end
        end
        S_RD1: begin
          rd_addr <= AW'(depth - DW'(2));
          state   <= S_RD2;
        end
        S_RD2: begin
          first <= rd_data;
          state <= S_EXEC;
        end
        S_EXEC: begin
          second <= rd_data;
          if (cur.op_code == rpn_pkg::OP_DIV || cur.op_code == rpn_pkg::OP_REM) begin
            div_start <= 1'b1;
            state     <= S_DIV;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (cur.op_code != rpn_pkg::OP_DIV && cur.op_code != rpn_pkg::OP_REM) begin
            wr_en   <= 1'b1;
            wr_addr <= AW'(depth - DW'(2));
            wr_data <= alu;
            depth   <= depth - DW'(1);
            state   <= S_FIN;
          end else if (!div_start && rhs == 32'd0) begin
            if (err == rpn_pkg::ERR_NONE) err <= rpn_pkg::ERR_DIVZERO;
            wr_en   <= 1'b1;
            wr_addr <= AW'(depth - DW'(2));
            wr_data <= '0;
            depth   <= depth - DW'(1);
            state   <= S_FIN;
          end else if (div_done) begin
            wr_en   <= 1'b1;
            wr_addr <= AW'(depth - DW'(2));
            wr_data <= (cur.op_code == rpn_pkg::OP_DIV) ? quo : rem;
            depth   <= depth - DW'(1);
            state   <= S_FIN;
          end
        end
        S_FIN: begin
          // pending write lands at this edge; top-of-stack read follows it
          rd_addr <= AW'(depth - DW'(1));
          state   <= cur.last ? S_RDW : S_IDLE;
        end
        S_RDW: begin
          state <= S_OUT;
        end
        S_OUT: begin
          // rd_data holds the top of stack; wait for the result slot
          if (!res_valid || !res_stall) begin
            res_valid <= 1'b1;
            res.value <= (depth == '0) ? 32'sd0 : rd_data;
            res.error <= (depth == '0 && err == rpn_pkg::ERR_NONE)
                         ? rpn_pkg::ERR_UNDERFLOW : err;
            depth <= '0;
            err   <= rpn_pkg::ERR_NONE;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* rtl/core/rpn_stack_evaluator_unit.sv */
// Top level of the stack evaluator: APB register, token queue, execution engine.
// Depends on rpn_pkg, rpn_fifo, rpn_back, rpn_stack_evaluator_unit_assert.svh.
//
//  channel | direction | handshake
//  tok     | in        | tok_valid / tok_stall
//  res     | out       | res_valid / res_stall
//  apb     | in        | psel penable pwrite, pready tied high
//
// Per token, after the queue: an operand is pushed; add, sub and mul read two
// entries and write back; divide and remainder also wait on the bit-serial
// divider, cut short on a zero divisor. A final token then reads the top of
// stack. Synchronous reset clears depth, errors and mode. Queue fills while
// the engine works; a stalled result holds the engine in its output step.
`include "rpn_stack_evaluator_unit_assert.svh"
module rpn_stack_evaluator_unit #(
  parameter int unsigned STACK_DEPTH = rpn_pkg::StackDepthDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [1:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  logic             tok_valid,
  output logic             tok_stall,
  input  rpn_pkg::token_t  tok,
  output logic             res_valid,
  input  logic             res_stall,
  output rpn_pkg::result_t res
);
  logic mode, q_full, q_empty, q_pop, busy;
  rpn_pkg::token_t q_data;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {31'd0, mode} : 32'd0;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) mode <= 1'b0;
    else if (psel && penable && pwrite && paddr == 2'd0) mode <= pwdata[0];
  end

  assign tok_stall = q_full;

  rpn_fifo u_q (
    .clk(clk), .rst(rst), .push(tok_valid && !q_full), .push_data(tok), .full(q_full),
    .pop(q_pop), .empty(q_empty), .pop_data(q_data)
  );

  rpn_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk(clk), .rst(rst), .mode(mode), .tok_valid(!q_empty), .tok(q_data),
    .tok_pop(q_pop), .busy(busy), .res_valid(res_valid), .res_stall(res_stall),
    .res(res)
  );

  `RSE_ASSERT(a_pop_needs_data, clk, rst, q_pop |-> !q_empty, "pop from empty queue")
  `RSE_ASSERT(a_pop_idle, clk, rst, q_pop |-> !busy, "pop while engine busy")
  `RSE_ASSERT(a_res_hold, clk, rst, (res_valid && res_stall) |=> $stable(res), "result moved")
  `RSE_ASSERT_RST(a_rst_idle, clk, $past(rst) |-> !res_valid, "result after reset")
endmodule

/* verif/rpn_result_checker.sv */
// Checker for the stack evaluator: watches the token and result channels,
// predicts each expression's result and compares. Depends on rpn_pkg.
module rpn_result_checker #(
  parameter int unsigned STACK_DEPTH = rpn_pkg::StackDepthDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [1:0]       paddr,
  input  logic [31:0]      pwdata,
  input  logic             tok_valid,
  input  logic             tok_stall,
  input  rpn_pkg::token_t  tok,
  input  logic             res_valid,
  input  logic             res_stall,
  input  rpn_pkg::result_t res,
  output int               fail_count,
  output int               pending_count,
  output int               result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0]      eval_stack [STACK_DEPTH];
  int unsigned      eval_depth;
  logic [1:0]       eval_err;
  logic             prefix_mode;
  rpn_pkg::result_t expected_results [$];

  function automatic void flag_error(logic [1:0] code);
    if (eval_err == rpn_pkg::ERR_NONE) eval_err = code;
  endfunction

  // Evaluate one operator against the predicted stack
  function automatic void apply_op(logic [2:0] op);
    logic [31:0] first, second, lhs, rhs, r;
    if (op > rpn_pkg::OP_REM) return;
    if (eval_depth < 2) begin
      flag_error(rpn_pkg::ERR_UNDERFLOW);
      return;
    end
    first = eval_stack[eval_depth - 1];
    second = eval_stack[eval_depth - 2];
    eval_depth -= 2;
    lhs = prefix_mode ? first : second;
    rhs = prefix_mode ? second : first;
    r = '0;
    case (op)
      rpn_pkg::OP_ADD: r = lhs + rhs;
      rpn_pkg::OP_SUB: r = lhs - rhs;
      rpn_pkg::OP_MUL: r = lhs * rhs;
      default: begin
        if (rhs == 0) begin
          flag_error(rpn_pkg::ERR_DIVZERO);
        end else if (lhs == 32'h8000_0000 && rhs == 32'hFFFF_FFFF) begin
          r = (op == rpn_pkg::OP_DIV) ? 32'h8000_0000 : 32'h0;
        end else if (op == rpn_pkg::OP_DIV) begin
          r = $signed(lhs) / $signed(rhs);
        end else begin
          r = $signed(lhs) % $signed(rhs);
        end
      end
    endcase
    eval_stack[eval_depth] = r;
    eval_depth += 1;
  endfunction

  // Predict on each accepted token, compare on each accepted result
  always @(posedge clk) begin
    rpn_pkg::result_t want;
    logic [31:0] top;
    if (rst) begin
      eval_depth = 0;
      eval_err = rpn_pkg::ERR_NONE;
      prefix_mode = 1'b0;
      expected_results.delete();
      fail_count <= 0;
      pending_count <= 0;
      result_count <= 0;
    end else begin
      if (psel && penable && pwrite && paddr == 2'd0) prefix_mode = pwdata[0];
      if (tok_valid && !tok_stall) begin
        if (tok.cmd == rpn_pkg::CMD_OPERAND) begin
          if (eval_depth >= STACK_DEPTH) flag_error(rpn_pkg::ERR_OVERFLOW);
          else begin
            eval_stack[eval_depth] = {1'b0, tok.operand};
            eval_depth += 1;
          end
        end else begin
          apply_op(tok.op_code);
        end
        if (tok.last) begin
          top = '0;
          if (eval_depth > 0) top = eval_stack[eval_depth - 1];
          else flag_error(rpn_pkg::ERR_UNDERFLOW);
          want.value = top;
          want.error = eval_err;
          expected_results.push_back(want);
          eval_depth = 0;
          eval_err = rpn_pkg::ERR_NONE;
        end
      end
      if (res_valid && !res_stall) begin
        result_count <= result_count + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result value=%0d error=%0d", $time, res.value, res.error);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (res.value !== want.value || res.error !== want.error) begin
            $display("%0t: expected value=%0d error=%0d, got value=%0d error=%0d",
                     $time, want.value, want.error, res.value, res.error);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_count <= expected_results.size();
    end
  end
endmodule

/* verif/tb.sv */
// Testbench top for rpn_stack_evaluator_unit: drives tokens and the mode register,
// stalls results, gives the verdict. Depends on rpn_pkg, the unit, rpn_result_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic tok_valid, tok_stall, res_valid, res_stall;
  rpn_pkg::token_t tok;
  rpn_pkg::result_t res;
  int fail_count, pending_count, result_count;
  int token_count;
  bit long_hold;

  rpn_stack_evaluator_unit dut (.*);

  rpn_result_checker #(.STACK_DEPTH(rpn_pkg::StackDepthDefault)) checker_i (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .tok_valid, .tok_stall,
    .tok, .res_valid, .res_stall, .res, .fail_count, .pending_count, .result_count
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver stall pattern, with a long hold-off on request
  initial begin
    res_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        res_stall <= 1'b1;
        repeat (600) @(posedge clk);
        res_stall <= 1'b0;
        long_hold = 0;
      end else begin
        case ($urandom_range(0, 3))
          0: res_stall <= 1'b1;
          1: res_stall <= ($urandom_range(0, 3) == 0);
          default: res_stall <= 1'b0;
        endcase
      end
    end
  end

  // Send one token: hold until accepted, then maybe leave a gap
  task automatic send_token(input logic c, input logic [30:0] v, input logic [2:0] op,
                            input logic l);
    tok_valid <= 1'b1;
    tok <= '{cmd: c, operand: v, op_code: op, last: l};
    do @(posedge clk); while (tok_stall);
    token_count++;
    if ($urandom_range(0, 7) == 0) begin
      tok_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic push(input logic [30:0] v, input logic l = 1'b0);
    send_token(rpn_pkg::CMD_OPERAND, v, 3'($urandom), l);
  endtask

  task automatic oper(input logic [2:0] op, input logic l = 1'b0);
    send_token(rpn_pkg::CMD_OPERATOR, 31'($urandom), op, l);
  endtask

  task automatic drain();
    tok_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= 2'd0; pwdata <= {31'd0, m};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Random literal biased toward edges
  function automatic logic [30:0] rand_lit();
    case ($urandom_range(0, 5))
      0: return 31'($urandom_range(0, 3));
      1: return 31'(32'h7FFF_FFFF - $urandom_range(0, 2));
      2: return 31'($urandom_range(0, 100));
      default: return 31'($urandom);
    endcase
  endfunction

  // Random expression from n operands and a final push or operator, broken on request
  task automatic random_expr(input int n, input bit broken);
    int held;
    held = 0;
    for (int i = 0; i < n; i++) begin
      push(rand_lit());
      held++;
      while (held >= 2 && $urandom_range(0, 2) == 0) begin
        oper(3'($urandom_range(0, 4)));
        held--;
      end
    end
    if (broken) begin
      for (int k = $urandom_range(0, 3); k > 0; k--) oper(3'($urandom_range(0, 7)));
    end else begin
      while (held > 1) begin
        oper(3'($urandom_range(0, 4)));
        held--;
      end
    end
    if ($urandom_range(0, 1)) push(rand_lit(), 1'b1);
    else oper(3'($urandom_range(0, broken ? 7 : 4)), 1'b1);
  endtask

  initial begin
    rst = 1'b1;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    tok_valid = 0; tok = '0; long_hold = 0; token_count = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: each operator, extremes, special cases, postfix
    write_mode(1'b0);
    push(31'h7FFF_FFFF); push(31'h7FFF_FFFF); oper(rpn_pkg::OP_ADD, 1);
    push(0); push(31'h7FFF_FFFF); oper(rpn_pkg::OP_SUB); push(1); oper(rpn_pkg::OP_SUB, 1);
    push(31'h7FFF_FFFF); push(3); oper(rpn_pkg::OP_MUL, 1);
    push(7); push(0); oper(rpn_pkg::OP_DIV, 1);
    push(7); push(0); oper(rpn_pkg::OP_REM); push(5); oper(rpn_pkg::OP_DIV, 1);
    // min int / -1 via (0 - max - 1) and (0 - 1)
    push(0); push(31'h7FFF_FFFF); oper(rpn_pkg::OP_SUB); push(1); oper(rpn_pkg::OP_SUB);
    push(0); push(1); oper(rpn_pkg::OP_SUB); oper(rpn_pkg::OP_DIV, 1);
    push(0); push(31'h7FFF_FFFF); oper(rpn_pkg::OP_SUB); push(1); oper(rpn_pkg::OP_SUB);
    push(0); push(1); oper(rpn_pkg::OP_SUB); oper(rpn_pkg::OP_REM, 1);
    oper(rpn_pkg::OP_ADD, 1);
    push(9); oper(3'd6); push(4); oper(3'd7, 1);
    push(1); push(2); push(3, 1);
    oper(3'd5, 1);
    drain();
    // Overflow: fill past the stack
    for (int i = 0; i < rpn_pkg::StackDepthDefault + 2; i++) push(31'(i));
    push(5, 1);
    drain();

    // Prefix mode directed: 10 - 3, 10 % 3, 8 / 0 fed reversed
    write_mode(1'b1);
    push(3); push(10); oper(rpn_pkg::OP_SUB, 1);
    push(3); push(10); oper(rpn_pkg::OP_REM, 1);
    push(0); push(8); oper(rpn_pkg::OP_DIV, 1);
    drain();

    // Random phases across modes
    for (int ph = 0; ph < 6; ph++) begin
      write_mode(ph[0]);
      if (ph == 2) long_hold = 1;
      while (token_count < 300 * (ph + 1) - 140) begin
        if ($urandom_range(0, 9) == 0) random_expr($urandom_range(1, 6), 1);
        else if ($urandom_range(0, 40) == 0) random_expr($urandom_range(60, 66), 0);
        else random_expr($urandom_range(1, 8), 0);
        if ($urandom_range(0, 5) == 0) begin
          tok_valid <= 1'b0;
          repeat ($urandom_range(1, 20)) @(posedge clk);
        end
      end
      drain();
    end
    write_mode(1'b0);

    $display("Sent %0d tokens, checked %0d results in both notations.",
             token_count, result_count);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

/* rpn_stack_evaluator_unit.f */
+incdir+rtl/core
rtl/core/rpn_pkg.sv
rtl/core/rpn_fifo.sv
rtl/core/rpn_divider.sv
rtl/core/rpn_back.sv
rtl/core/rpn_stack_evaluator_unit.sv
verif/rpn_result_checker.sv
verif/tb.sv
